>>> sv/text_console_character_writer_core_defines.svh
// ----------------------------------------------------------------------------
// Text console writer assertion macros
// Shared property wrappers for the checks in the console sequencer.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CHARACTER_WRITER_CORE_DEFINES_SVH
`define TEXT_CONSOLE_CHARACTER_WRITER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define TCCW_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tccw check failed");

// Next-cycle implication, checked outside reset.
`define TCCW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tccw check failed");

`endif

>>> sv/tccw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccw_pkg
// Shared types, codes and helpers of the text console writer.
// ----------------------------------------------------------------------------
package tccw_pkg;

	localparam int KIND_W      = 2;
	localparam int CHAR_W      = 8;
	localparam int ATTR_W      = 8;
	localparam int CELL_W      = CHAR_W + ATTR_W;
	localparam int ROW_FIELD_W = 5;
	localparam int COL_FIELD_W = 7;

	localparam int DEF_SCREEN_ROWS = 25;
	localparam int DEF_SCREEN_COLS = 80;
	localparam int DEF_TAB_WIDTH   = 8;

	// Upper bound on the column count; sizes the tab stop mask.
	localparam int MAX_COLS  = 128;
	localparam int COL_IDX_W = 7;

	localparam logic [KIND_W-1:0] KIND_PUT  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_READ = 2'd1;
	localparam logic [KIND_W-1:0] KIND_SET  = 2'd2;

	localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
	localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
	localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
	localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;
	localparam logic [CHAR_W-1:0] CH_NUL       = 8'd0;
	localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h0F;

	// Register port
	localparam int PADDR_W   = 3;
	localparam int PDATA_W   = 32;
	localparam int REG_IDX_W = 1;
	localparam logic [REG_IDX_W-1:0] REG_TEXT_ATTRIBUTE = 1'b0;

	typedef struct packed {
		logic [KIND_W-1:0]      kind;
		logic [CHAR_W-1:0]      char_code;
		logic [ROW_FIELD_W-1:0] cell_row;
		logic [COL_FIELD_W-1:0] cell_col;
	} req_word_t;

	typedef struct packed {
		logic [CHAR_W-1:0]      read_char;
		logic [ATTR_W-1:0]      read_attr;
		logic [ROW_FIELD_W-1:0] cursor_row;
		logic [COL_FIELD_W-1:0] cursor_col;
		logic                   scrolled;
	} rsp_word_t;

	// Bit c is set when column c is a tab stop.
	function automatic logic [MAX_COLS-1:0] tab_stop_mask(input int width);
		logic [MAX_COLS-1:0] mask;
		int phase;
		mask  = '0;
		phase = 0;
		for (int c = 0; c < MAX_COLS; c++) begin
			mask[c] = (phase == 0);
			phase   = phase + 1;
			if (phase >= width) begin
				phase = 0;
			end
		end
		return mask;
	endfunction

endpackage

>>> sv/text_console_character_writer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_character_writer_core
// Teletype text console: cell buffer in block memory, cursor, scroll walk.
// ----------------------------------------------------------------------------
//
//   channel   handshake                        payload
//   req       req_valid / req_stall            req_word  (kind, char, row, col)
//   rsp       rsp_valid / rsp_stall            rsp_word  (cell, cursor, scrolled)
//   config    psel / penable / pwrite, pready  paddr, pwdata, prdata
//
// After reset a clearing pass writes every cell, one per cycle, while
// req_stall stays high.
// Put, set cursor and idle codes go from idle straight to the done state;
// a cell read passes a read state first, waiting on the registered read
// data of the cell memory. A tab prints its first space when taken and
// the rest in the tab state, up to the next tab stop. A scroll walks the
// whole buffer through the single read and write port.
// A result waits in the output register; a new word is taken while it sits
// there, and only the next result waits for rsp_stall to drop.
// ----------------------------------------------------------------------------
module text_console_character_writer_core #(
	parameter int SCREEN_ROWS = tccw_pkg::DEF_SCREEN_ROWS,
	parameter int SCREEN_COLS = tccw_pkg::DEF_SCREEN_COLS,
	parameter int TAB_WIDTH   = tccw_pkg::DEF_TAB_WIDTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_stall,
	input  tccw_pkg::req_word_t          req_word,
	output logic                         rsp_valid,
	input  logic                         rsp_stall,
	output tccw_pkg::rsp_word_t          rsp_word,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [tccw_pkg::PADDR_W-1:0] paddr,
	input  logic [tccw_pkg::PDATA_W-1:0] pwdata,
	output logic [tccw_pkg::PDATA_W-1:0] prdata,
	output logic                         pready
);

	localparam int NCELLS = SCREEN_ROWS * SCREEN_COLS;
	localparam int AW     = $clog2(NCELLS);

	logic [tccw_pkg::ATTR_W-1:0] text_attribute;
	logic                        mem_we;
	logic [AW-1:0]               mem_waddr;
	logic [tccw_pkg::CELL_W-1:0] mem_wdata;
	logic                        mem_re;
	logic [AW-1:0]               mem_raddr;
	logic [tccw_pkg::CELL_W-1:0] mem_rdata;
	logic                        slot_free;
	logic                        rsp_push;
	tccw_pkg::rsp_word_t         rsp_next;
	logic                        out_vld_q;
	tccw_pkg::rsp_word_t         out_word_q;

	tccw_apb_regs u_regs (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.text_attribute (text_attribute)
	);

	tccw_cell_mem #(
		.DEPTH  (NCELLS),
		.ADDR_W (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	tccw_seq #(
		.SCREEN_ROWS (SCREEN_ROWS),
		.SCREEN_COLS (SCREEN_COLS),
		.TAB_WIDTH   (TAB_WIDTH)
	) u_seq (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_valid      (req_valid),
		.req_stall      (req_stall),
		.req_word       (req_word),
		.text_attribute (text_attribute),
		.mem_we         (mem_we),
		.mem_waddr      (mem_waddr),
		.mem_wdata      (mem_wdata),
		.mem_re         (mem_re),
		.mem_raddr      (mem_raddr),
		.mem_rdata      (mem_rdata),
		.slot_free      (slot_free),
		.rsp_push       (rsp_push),
		.rsp_next       (rsp_next)
	);

	// Output register: free when empty or when its word leaves this cycle
	assign slot_free = !out_vld_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (rsp_push) begin
			out_vld_q <= 1'b1;
		end else if (!rsp_stall) begin
			// drop the word once taken
			out_vld_q <= 1'b0;
		end
	end

	// Load payload only on push, so a stalled word holds
	always_ff @(posedge clk) begin
		if (rsp_push) begin
			out_word_q <= rsp_next;
		end
	end

	assign rsp_valid = out_vld_q;
	assign rsp_word  = out_word_q;

endmodule

>>> sv/tccw_cell_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccw_cell_mem
// Cell buffer: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tccw_cell_mem #(
	parameter int DEPTH  = tccw_pkg::DEF_SCREEN_ROWS * tccw_pkg::DEF_SCREEN_COLS,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [ADDR_W-1:0]           waddr,
	input  logic [tccw_pkg::CELL_W-1:0] wdata,
	input  logic                        re,
	input  logic [ADDR_W-1:0]           raddr,
	output logic [tccw_pkg::CELL_W-1:0] rdata
);

	logic [tccw_pkg::CELL_W-1:0] mem [DEPTH];
	logic [tccw_pkg::CELL_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> sv/tccw_apb_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccw_apb_regs
// Register port holding the text attribute.
// ----------------------------------------------------------------------------
module tccw_apb_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [tccw_pkg::PADDR_W-1:0] paddr,
	input  logic [tccw_pkg::PDATA_W-1:0] pwdata,
	output logic [tccw_pkg::PDATA_W-1:0] prdata,
	output logic                         pready,
	output logic [tccw_pkg::ATTR_W-1:0]  text_attribute
);

	logic [tccw_pkg::ATTR_W-1:0]    attr_q;
	logic [tccw_pkg::REG_IDX_W-1:0] reg_idx;
	logic                           wr_en;

	assign reg_idx = paddr[tccw_pkg::PADDR_W-1:2];
	assign wr_en   = psel && penable && pwrite && pready;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= tccw_pkg::ATTR_RESET;
		end else if (wr_en && (reg_idx == tccw_pkg::REG_TEXT_ATTRIBUTE)) begin
			attr_q <= pwdata[tccw_pkg::ATTR_W-1:0];
		end
	end

	always_comb begin
		unique case (reg_idx)
			tccw_pkg::REG_TEXT_ATTRIBUTE: prdata = tccw_pkg::PDATA_W'(attr_q);
			default:                      prdata = '0;
		endcase
	end

	assign text_attribute = attr_q;

endmodule

>>> sv/tccw_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccw_seq
// Console sequencer: cursor, character decode, cell writes and scroll walk.
// ----------------------------------------------------------------------------
`include "text_console_character_writer_core_defines.svh"

module tccw_seq #(
	parameter int SCREEN_ROWS = tccw_pkg::DEF_SCREEN_ROWS,
	parameter int SCREEN_COLS = tccw_pkg::DEF_SCREEN_COLS,
	parameter int TAB_WIDTH   = tccw_pkg::DEF_TAB_WIDTH,
	localparam int NCELLS     = SCREEN_ROWS * SCREEN_COLS,
	localparam int AW         = $clog2(NCELLS)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_stall,
	input  tccw_pkg::req_word_t         req_word,
	input  logic [tccw_pkg::ATTR_W-1:0] text_attribute,
	output logic                        mem_we,
	output logic [AW-1:0]               mem_waddr,
	output logic [tccw_pkg::CELL_W-1:0] mem_wdata,
	output logic                        mem_re,
	output logic [AW-1:0]               mem_raddr,
	input  logic [tccw_pkg::CELL_W-1:0] mem_rdata,
	input  logic                        slot_free,
	output logic                        rsp_push,
	output tccw_pkg::rsp_word_t         rsp_next
);

	localparam int CNT_W    = $clog2(NCELLS + 1);
	localparam int RW       = $clog2(SCREEN_ROWS);
	localparam int CW       = $clog2(SCREEN_COLS);
	localparam int BOT_BASE = (SCREEN_ROWS - 1) * SCREEN_COLS;
	localparam logic [tccw_pkg::MAX_COLS-1:0] TAB_STOPS = tccw_pkg::tab_stop_mask(TAB_WIDTH);

	localparam logic [2:0] ST_CLEAR  = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_READ   = 3'd2;
	localparam logic [2:0] ST_TAB    = 3'd3;
	localparam logic [2:0] ST_SCROLL = 3'd4;
	localparam logic [2:0] ST_DONE   = 3'd5;

	logic [2:0]                  state_q;
	logic [RW-1:0]               row_q;
	logic [CW-1:0]               col_q;
	logic [AW-1:0]               clr_q;
	logic [CNT_W-1:0]            scan_q;
	logic                        wr_vld_s1;
	logic [AW-1:0]               wr_addr_s1;
	logic                        wr_bot_s1;
	logic                        scrolled_q;
	logic [tccw_pkg::CHAR_W-1:0] rd_char_q;
	logic [tccw_pkg::ATTR_W-1:0] rd_attr_q;

	logic                        accept;
	logic                        last_col;
	logic                        last_row;
	logic [CW-1:0]               step_col;
	logic [RW-1:0]               step_row;
	logic                        step_scroll;
	logic                        tab_done;
	logic [31:0]                 row_ext;
	logic [31:0]                 col_ext;
	logic [RW-1:0]               clamp_row;
	logic [CW-1:0]               clamp_col;
	logic [AW-1:0]               cur_addr;
	logic [AW-1:0]               rd_addr;
	logic                        scan_issue;
	logic                        scan_bottom;
	logic [AW-1:0]               scan_raddr;
	logic [tccw_pkg::CHAR_W-1:0] put_ch;
	logic                        put_write;

	assign accept    = req_valid && (state_q == ST_IDLE);
	assign req_stall = (state_q != ST_IDLE);

	// One printing step from the current cursor
	assign last_col    = (col_q == CW'(SCREEN_COLS - 1));
	assign last_row    = (row_q == RW'(SCREEN_ROWS - 1));
	assign step_col    = last_col ? '0 : col_q + CW'(1);
	assign step_row    = (last_col && !last_row) ? row_q + RW'(1) : row_q;
	assign step_scroll = last_col && last_row;
	assign tab_done    = TAB_STOPS[tccw_pkg::COL_IDX_W'(step_col)];

	assign row_ext   = 32'(req_word.cell_row);
	assign col_ext   = 32'(req_word.cell_col);
	assign clamp_row = (row_ext > 32'(SCREEN_ROWS - 1)) ? RW'(SCREEN_ROWS - 1) : RW'(row_ext);
	assign clamp_col = (col_ext > 32'(SCREEN_COLS - 1)) ? CW'(SCREEN_COLS - 1) : CW'(col_ext);

	assign cur_addr = AW'(32'(row_q) * 32'(SCREEN_COLS) + 32'(col_q));
	assign rd_addr  = AW'(32'(clamp_row) * 32'(SCREEN_COLS) + 32'(clamp_col));

	// Scroll walk: destination scan_q takes the cell one row below; on the bottom row it keeps its attribute, turns blank
	assign scan_issue  = (state_q == ST_SCROLL) && (32'(scan_q) < 32'(NCELLS));
	assign scan_bottom = (32'(scan_q) >= 32'(BOT_BASE));
	assign scan_raddr  = scan_bottom ? scan_q[AW-1:0] : AW'(32'(scan_q) + 32'(SCREEN_COLS));

	assign put_ch    = (req_word.char_code == tccw_pkg::CH_NUL) ? tccw_pkg::CH_SPACE
		: req_word.char_code;
	assign put_write = accept && (req_word.kind == tccw_pkg::KIND_PUT)
		&& (req_word.char_code != tccw_pkg::CH_NEWLINE)
		&& (req_word.char_code != tccw_pkg::CH_BACKSPACE);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = cur_addr;
		mem_wdata = {text_attribute, put_ch};
		mem_re    = 1'b0;
		mem_raddr = scan_raddr;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = {tccw_pkg::ATTR_RESET, tccw_pkg::CH_NUL};
			end
			ST_IDLE: begin
				mem_we = put_write;
				if (req_word.char_code == tccw_pkg::CH_TAB) begin
					mem_wdata = {text_attribute, tccw_pkg::CH_SPACE};
				end
				mem_re    = accept && (req_word.kind == tccw_pkg::KIND_READ);
				mem_raddr = rd_addr;
			end
			ST_TAB: begin
				mem_we    = 1'b1;
				mem_wdata = {text_attribute, tccw_pkg::CH_SPACE};
			end
			ST_SCROLL: begin
				mem_re    = scan_issue;
				mem_we    = wr_vld_s1;
				mem_waddr = wr_addr_s1;
				mem_wdata = wr_bot_s1
					? {mem_rdata[tccw_pkg::CELL_W-1:tccw_pkg::CHAR_W], tccw_pkg::CH_SPACE}
					: mem_rdata;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			row_q      <= '0;
			col_q      <= '0;
			clr_q      <= '0;
			scan_q     <= '0;
			wr_vld_s1  <= 1'b0;
			wr_addr_s1 <= '0;
			wr_bot_s1  <= 1'b0;
			scrolled_q <= 1'b0;
			rd_char_q  <= '0;
			rd_attr_q  <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(NCELLS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						scrolled_q <= 1'b0;
						rd_char_q  <= '0;
						rd_attr_q  <= '0;
						scan_q     <= '0;
						state_q    <= ST_DONE;
						unique case (req_word.kind)
							tccw_pkg::KIND_PUT: begin
								unique case (req_word.char_code)
									tccw_pkg::CH_NEWLINE: begin
										col_q <= '0;
										if (!last_row) begin
											row_q <= row_q + RW'(1);
										end else begin
											scrolled_q <= 1'b1;
											state_q    <= ST_SCROLL;
										end
									end
									tccw_pkg::CH_BACKSPACE: begin
										if (col_q == '0 && row_q != '0) begin
											row_q <= row_q - RW'(1);
											col_q <= CW'(SCREEN_COLS - 1);
										end else if (col_q != '0) begin
											col_q <= col_q - CW'(1);
										end
									end
									default: begin
										row_q <= step_row;
										col_q <= step_col;
										if (step_scroll) begin
											scrolled_q <= 1'b1;
											state_q    <= ST_SCROLL;
										end else if ((req_word.char_code == tccw_pkg::CH_TAB)
											&& !tab_done) begin
											state_q <= ST_TAB;
										end
									end
								endcase
							end
							tccw_pkg::KIND_READ: begin
								state_q <= ST_READ;
							end
							tccw_pkg::KIND_SET: begin
								row_q <= clamp_row;
								col_q <= clamp_col;
							end
							default: begin
							end
						endcase
					end
				end
				ST_READ: begin
					rd_char_q <= mem_rdata[tccw_pkg::CHAR_W-1:0];
					rd_attr_q <= mem_rdata[tccw_pkg::CELL_W-1:tccw_pkg::CHAR_W];
					state_q   <= ST_DONE;
				end
				ST_TAB: begin
					row_q <= step_row;
					col_q <= step_col;
					if (step_scroll) begin
						scrolled_q <= 1'b1;
						state_q    <= ST_SCROLL;
					end else if (tab_done) begin
						state_q <= ST_DONE;
					end
				end
				ST_SCROLL: begin
					wr_vld_s1  <= scan_issue;
					wr_addr_s1 <= scan_q[AW-1:0];
					wr_bot_s1  <= scan_bottom;
					if (scan_issue) begin
						scan_q <= scan_q + CNT_W'(1);
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp_push = (state_q == ST_DONE) && slot_free;

	assign rsp_next.read_char  = rd_char_q;
	assign rsp_next.read_attr  = rd_attr_q;
	assign rsp_next.cursor_row = tccw_pkg::ROW_FIELD_W'(row_q);
	assign rsp_next.cursor_col = tccw_pkg::COL_FIELD_W'(col_q);
	assign rsp_next.scrolled   = scrolled_q;

	// The scroll walk never reads the entry it writes in the same cycle
	`TCCW_ASSERT_SAME(a_no_rw_same_addr, clk, arst_n, mem_we && mem_re, mem_waddr != mem_raddr)
	// A scroll only runs with the cursor parked at the start of the bottom row
	`TCCW_ASSERT_SAME(a_scroll_cursor, clk, arst_n, state_q == ST_SCROLL,
		last_row && (col_q == '0))
	// Delayed scroll writes only happen inside the walk
	`TCCW_ASSERT_SAME(a_wr_in_scroll, clk, arst_n, wr_vld_s1, state_q == ST_SCROLL)
	// Once all reads are issued, the last write retires and the result follows
	`TCCW_ASSERT_NEXT(a_scroll_end, clk, arst_n, (state_q == ST_SCROLL) && !scan_issue,
		(state_q == ST_DONE) && !wr_vld_s1)

endmodule

>>> tb/console_shadow_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// console_shadow_checker
// Keeps a shadow screen, cursor and attribute register, works out the reply
// word owed for every accepted request word and compares each returned reply
// word field by field, oldest first.
// ----------------------------------------------------------------------------
module console_shadow_checker
	import tccw_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	input  logic               req_stall,
	input  req_word_t          req_word,
	input  logic               rsp_valid,
	input  logic               rsp_stall,
	input  rsp_word_t          rsp_word,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	input  logic               pready,
	output int                 fail_count,
	output int                 replies_owed
);

	localparam int ROWS  = DEF_SCREEN_ROWS;
	localparam int COLS  = DEF_SCREEN_COLS;
	localparam int TABW  = DEF_TAB_WIDTH;
	localparam int CELLS = ROWS * COLS;
	localparam logic [PADDR_W-1:0] ATTR_ADDR = PADDR_W'(4 * REG_TEXT_ATTRIBUTE);

	logic [CELL_W-1:0] screen [CELLS];
	int                cur_row;
	int                cur_col;
	logic [ATTR_W-1:0] text_attr;
	bit                scroll_seen;
	rsp_word_t         reply_queue [$];
	int                fails = 0;
	int                owed_count = 0;

	assign fail_count   = fails;
	assign replies_owed = owed_count;

	function automatic int clamp_to(int v, int ceiling);
		return (v > ceiling) ? ceiling : v;
	endfunction

	// Move rows up one; the bottom row keeps its attributes but turns blank.
	function automatic void scroll_screen();
		for (int i = 0; i < CELLS; i++) begin
			if (i < CELLS - COLS) begin
				screen[i] = screen[i + COLS];
			end else begin
				screen[i] = {screen[i][CELL_W-1:CHAR_W], CH_SPACE};
			end
		end
		scroll_seen = 1'b1;
	endfunction

	function automatic void line_feed();
		cur_col = 0;
		if (cur_row < ROWS - 1) begin
			cur_row++;
		end else begin
			scroll_screen();
		end
	endfunction

	function automatic void print_cell(logic [CHAR_W-1:0] ch);
		if (ch == CH_NUL) begin
			ch = CH_SPACE;
		end
		screen[cur_row * COLS + cur_col] = {text_attr, ch};
		if (cur_col < COLS - 1) begin
			cur_col++;
		end else begin
			line_feed();
		end
	endfunction

	function automatic void put_byte(logic [CHAR_W-1:0] ch);
		case (ch)
			CH_NEWLINE: begin
				line_feed();
			end
			CH_TAB: begin
				do print_cell(CH_SPACE); while (cur_col % TABW != 0);
			end
			CH_BACKSPACE: begin
				if (cur_col == 0 && cur_row != 0) begin
					cur_row--;
					cur_col = COLS - 1;
				end else if (cur_col != 0) begin
					cur_col--;
				end
			end
			default: begin
				print_cell(ch);
			end
		endcase
	endfunction

	// Apply one request word to the shadow state and return the reply it owes.
	function automatic rsp_word_t console_reply(req_word_t w);
		rsp_word_t r;
		int        idx;
		r           = '0;
		scroll_seen = 1'b0;
		case (w.kind)
			KIND_PUT: begin
				put_byte(w.char_code);
			end
			KIND_READ: begin
				idx = clamp_to(w.cell_row, ROWS - 1) * COLS + clamp_to(w.cell_col, COLS - 1);
				r.read_char = screen[idx][CHAR_W-1:0];
				r.read_attr = screen[idx][CELL_W-1:CHAR_W];
			end
			KIND_SET: begin
				cur_row = clamp_to(w.cell_row, ROWS - 1);
				cur_col = clamp_to(w.cell_col, COLS - 1);
			end
			default: begin
			end
		endcase
		r.cursor_row = ROW_FIELD_W'(cur_row);
		r.cursor_col = COL_FIELD_W'(cur_col);
		r.scrolled   = scroll_seen;
		return r;
	endfunction

	task automatic check_field(string field, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			fails++;
			$display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		rsp_word_t want;
		if (!arst_n) begin
			for (int i = 0; i < CELLS; i++) begin
				screen[i] = {ATTR_RESET, CH_NUL};
			end
			cur_row   = 0;
			cur_col   = 0;
			text_attr = ATTR_RESET;
			reply_queue.delete();
		end else begin
			if (psel && penable && pwrite && pready && paddr == ATTR_ADDR) begin
				text_attr = pwdata[ATTR_W-1:0];
			end
			// Check the reply before taking a new request: a reply never comes
			// back in the cycle its request goes in.
			if (rsp_valid && !rsp_stall) begin
				if (reply_queue.size() == 0) begin
					fails++;
					$display("%0t: reply word with none owed, actual %h", $time, rsp_word);
				end else begin
					want = reply_queue.pop_front();
					check_field("read_char", want.read_char, rsp_word.read_char);
					check_field("read_attr", want.read_attr, rsp_word.read_attr);
					check_field("cursor_row", want.cursor_row, rsp_word.cursor_row);
					check_field("cursor_col", want.cursor_col, rsp_word.cursor_col);
					check_field("scrolled", want.scrolled, rsp_word.scrolled);
				end
			end
			if (req_valid && !req_stall) begin
				reply_queue.push_back(console_reply(req_word));
			end
		end
		owed_count = reply_queue.size();
	end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the console core with a directed run of edge cases, then phases of
// random console traffic under several text attributes, with random gaps on
// the request side and random stalls on the reply side. A shadow checker
// beside the core predicts every reply word; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
	import tccw_pkg::*;

	// Kind code the core must treat as a no-op.
	localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;
	localparam logic [CHAR_W-1:0] CH_RETURN = 8'd13;
	localparam logic [PADDR_W-1:0] ATTR_ADDR = PADDR_W'(4 * REG_TEXT_ATTRIBUTE);
	// A scroll walks all 2000 cells, as does the clearing pass after reset.
	localparam int QUIET_LIMIT      = 12000;
	localparam int WORDS_PER_PHASE  = 225;
	localparam int ATTR_PHASES      = 4;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               req_valid = 1'b0;
	logic               req_stall;
	req_word_t          req_word  = '0;
	logic               rsp_valid;
	logic               rsp_stall = 1'b0;
	rsp_word_t          rsp_word;
	logic               psel      = 1'b0;
	logic               penable   = 1'b0;
	logic               pwrite    = 1'b0;
	logic [PADDR_W-1:0] paddr     = '0;
	logic [PDATA_W-1:0] pwdata    = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	// High while both sides run flat out, no gaps and no stalls.
	bit                 steady    = 1'b0;
	int                 fail_count;
	int                 replies_owed;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	text_console_character_writer_core DUT (
		.clk, .arst_n,
		.req_valid, .req_stall, .req_word,
		.rsp_valid, .rsp_stall, .rsp_word,
		.psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
	);

	console_shadow_checker screen_check (
		.clk, .arst_n,
		.req_valid, .req_stall, .req_word,
		.rsp_valid, .rsp_stall, .rsp_word,
		.psel, .penable, .pwrite, .paddr, .pwdata, .pready,
		.fail_count, .replies_owed
	);

	// Stall the reply side about a third of the time, except in steady stretches.
	always @(posedge clk) begin
		rsp_stall <= !steady && ($urandom_range(0, 99) < 33);
	end

	// Abort when no word moves on either channel for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("FAIL text_console_character_writer_core");
		$finish;
	end

	function automatic req_word_t console_word(logic [KIND_W-1:0] kind,
			logic [CHAR_W-1:0] ch, logic [ROW_FIELD_W-1:0] row,
			logic [COL_FIELD_W-1:0] col);
		req_word_t w;
		w.kind      = kind;
		w.char_code = ch;
		w.cell_row  = row;
		w.cell_col  = col;
		return w;
	endfunction

	// Mostly printing, with reads and cursor moves steered toward the lower
	// right of the screen half the time so that printed cells get read back
	// and the last row, with its scrolls, is visited often.
	function automatic req_word_t random_console_word();
		req_word_t w;
		int        pick;
		w.kind      = KIND_PUT;
		w.char_code = CHAR_W'($urandom_range(0, 255));
		w.cell_row  = ROW_FIELD_W'($urandom_range(0, 31));
		w.cell_col  = COL_FIELD_W'($urandom_range(0, 127));
		pick = $urandom_range(0, 99);
		if (pick < 60) begin
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				w.char_code = CH_NEWLINE;
			end else if (pick < 16) begin
				w.char_code = CH_TAB;
			end else if (pick < 24) begin
				w.char_code = CH_BACKSPACE;
			end else if (pick < 27) begin
				w.char_code = CH_NUL;
			end
		end else begin
			if (pick < 80) begin
				w.kind = KIND_READ;
			end else if (pick < 95) begin
				w.kind = KIND_SET;
			end else begin
				w.kind = KIND_NONE;
			end
			if ($urandom_range(0, 1) == 1) begin
				w.cell_row = ROW_FIELD_W'($urandom_range(20, 24));
				w.cell_col = COL_FIELD_W'($urandom_range(60, 79));
			end
		end
		return w;
	endfunction

	// Offer one word, after a random gap, and hold it until it is taken.
	task automatic send_word(input req_word_t w);
		while (!steady && $urandom_range(0, 99) < 33) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req_word  <= w;
		do @(posedge clk); while (!(req_valid && !req_stall));
	endtask

	// Drop valid and hold off until every owed reply word has come back.
	task automatic wait_for_replies();
		req_valid <= 1'b0;
		do @(negedge clk); while (replies_owed != 0);
		@(posedge clk);
	endtask

	// Setup phase, then access phase; junk in the upper data bits.
	task automatic write_text_attribute(input logic [ATTR_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ATTR_ADDR;
		pwdata  <= {(PDATA_W - ATTR_W)'($urandom()), value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	initial begin : stimulus
		logic [ATTR_W-1:0] attr;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Directed run, under the reset attribute.
		send_word(console_word(KIND_READ, 8'h00, 5'd0, 7'd0));       // reset cell
		send_word(console_word(KIND_READ, 8'hFF, 5'd31, 7'd127));    // clamped read
		send_word(console_word(KIND_NONE, 8'hFF, 5'd31, 7'd127));    // unused kind
		send_word(console_word(KIND_PUT, CH_NUL, 5'd0, 7'd0));       // zero byte prints a space
		send_word(console_word(KIND_PUT, 8'h41, 5'd0, 7'd0));
		send_word(console_word(KIND_PUT, 8'hFF, 5'd31, 7'd127));
		send_word(console_word(KIND_PUT, CH_RETURN, 5'd0, 7'd0));    // stored as is
		send_word(console_word(KIND_PUT, CH_TAB, 5'd0, 7'd0));       // col 4 to 8
		send_word(console_word(KIND_PUT, CH_TAB, 5'd0, 7'd0));       // full tab, 8 to 16
		send_word(console_word(KIND_PUT, CH_BACKSPACE, 5'd0, 7'd0));
		send_word(console_word(KIND_READ, 8'h00, 5'd0, 7'd0));
		send_word(console_word(KIND_SET, 8'h00, 5'd0, 7'd0));
		send_word(console_word(KIND_PUT, CH_BACKSPACE, 5'd0, 7'd0)); // stuck at home
		send_word(console_word(KIND_SET, 8'h00, 5'd1, 7'd0));
		send_word(console_word(KIND_PUT, CH_BACKSPACE, 5'd0, 7'd0)); // back to row above
		send_word(console_word(KIND_PUT, 8'h5A, 5'd0, 7'd0));        // last column wraps
		send_word(console_word(KIND_READ, 8'h00, 5'd0, 7'd79));
		send_word(console_word(KIND_SET, 8'h00, 5'd31, 7'd127));     // clamped cursor
		send_word(console_word(KIND_PUT, 8'h78, 5'd0, 7'd0));        // last cell scrolls
		send_word(console_word(KIND_READ, 8'h00, 5'd23, 7'd79));
		send_word(console_word(KIND_READ, 8'h00, 5'd31, 7'd127));    // blanked bottom row
		send_word(console_word(KIND_SET, 8'h00, 5'd24, 7'd75));
		send_word(console_word(KIND_PUT, CH_TAB, 5'd0, 7'd0));       // tab wraps and scrolls
		send_word(console_word(KIND_PUT, CH_NEWLINE, 5'd0, 7'd0));   // newline scrolls
		send_word(console_word(KIND_SET, 8'h00, 5'd0, 7'd40));
		send_word(console_word(KIND_PUT, CH_NEWLINE, 5'd0, 7'd0));

		// Random phases, each under its own attribute: both extremes, then random.
		for (int phase = 0; phase < ATTR_PHASES; phase++) begin
			wait_for_replies();
			case (phase)
				0: attr = 8'h00;
				1: attr = 8'hFF;
				default: attr = ATTR_W'($urandom_range(0, 255));
			endcase
			write_text_attribute(attr);
			for (int n = 0; n < WORDS_PER_PHASE; n++) begin
				steady <= (phase == 1 && n >= 60 && n < 180);
				send_word(random_console_word());
			end
		end

		wait_for_replies();
		repeat (8) @(posedge clk);
		if (fail_count == 0 && replies_owed == 0) begin
			$display("PASS text_console_character_writer_core");
		end else begin
			$display("FAIL text_console_character_writer_core");
		end
		$finish;
	end

endmodule

>>> sim.f
+incdir+sv
sv/tccw_pkg.sv
sv/tccw_cell_mem.sv
sv/tccw_apb_regs.sv
sv/tccw_seq.sv
sv/text_console_character_writer_core.sv
tb/console_shadow_checker.sv
tb/tb_top.sv
